>>> sv/qmr_pkg.sv
`default_nettype none

package qmr_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam int OP_W   = DATA_WIDTH + 1;
    localparam int PROD_W = 2 * OP_W;
    localparam int TERM_W = PROD_W - FRAC_BITS;
    localparam int SUM_W  = TERM_W + 2;

    localparam logic REQ_PRODUCT = 1'b0;
    localparam logic REQ_ROTATE  = 1'b1;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [OP_W-1:0]       op_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [TERM_W-1:0]     term_t;
    typedef logic signed [SUM_W-1:0]      sum_t;

    typedef struct packed {
        logic vld;
        logic rot;
    } ctl_t;

    localparam sum_t SAT_MAX = SUM_W'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    localparam sum_t SAT_MIN = -SAT_MAX - SUM_W'(1);

    localparam op_t ONE_Q = OP_W'(64'd1 << FRAC_BITS);

    function automatic term_t scale(input prod_t p);
        prod_t s;
        s = p >>> FRAC_BITS;
        return s[TERM_W-1:0];
    endfunction

    function automatic data_t sat(input sum_t s);
        data_t r;
        if (s > SAT_MAX)
        begin
            r = SAT_MAX[DATA_WIDTH-1:0];
        end
        else if (s < SAT_MIN)
        begin
            r = SAT_MIN[DATA_WIDTH-1:0];
        end
        else
        begin
            r = s[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/qmr_mult_stage.sv
`default_nettype none

module qmr_mult_stage
    import qmr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire ctl_t  ctl_in,
    input  wire op_t   lhs [4],
    input  wire op_t   rhs [4],
    output ctl_t       ctl_out,
    output prod_t      prod [16]
);

    ctl_t  ctl_reg;
    prod_t prod_reg [16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    // form all sixteen cross products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    prod_reg[i*4+j] <= PROD_W'(lhs[i]) * PROD_W'(rhs[j]);
                end
            end
        end
    end

    assign ctl_out = ctl_reg;
    assign prod    = prod_reg;

endmodule

`default_nettype wire

>>> sv/qmr_sum_stage.sv
`default_nettype none

module qmr_sum_stage
    import qmr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire ctl_t  ctl_in,
    input  wire prod_t prod [16],
    output ctl_t       ctl_out,
    output data_t      res [4]
);

    ctl_t  ctl_reg;
    data_t res_reg [4];
    sum_t  t [16];
    sum_t  s [4];

    always_comb
    begin
        for (int k = 0; k < 16; k++)
        begin
            t[k] = SUM_W'(scale(prod[k]));
        end
        s[0] = t[0]  - t[5]  - t[10] - t[15];
        s[1] = t[1]  + t[4]  + t[11] - t[14];
        s[2] = t[2]  - t[7]  + t[8]  + t[13];
        s[3] = t[3]  + t[6]  - t[9]  + t[12];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                res_reg[k] <= sat(s[k]);
            end
        end
    end

    assign ctl_out = ctl_reg;
    assign res     = res_reg;

endmodule

`default_nettype wire

>>> sv/quaternion_multiply_rotate.sv
// Channel | Signals                                         | Direction
// --------+-------------------------------------------------+----------
// in      | in_valid, in_stall, req_type, a_w..a_z, b_w..b_z | into block
// out     | out_valid, out_stall, res_w, res_x, res_y, res_z | out of block
//
// Four register stages: multiply, sum and saturate, multiply by conj(a)
// (or by one for a product), sum and saturate. One transaction enters per
// cycle unless the output stalls; the sixteen-multiplier stages set it.
// Reset clears the stage control bits only; data registers are not reset.
// A stalled valid result freezes every stage and raises in_stall the same cycle.
`default_nettype none

module quaternion_multiply_rotate
    import qmr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire logic  req_type,
    input  wire data_t a_w,
    input  wire data_t a_x,
    input  wire data_t a_y,
    input  wire data_t a_z,
    input  wire data_t b_w,
    input  wire data_t b_x,
    input  wire data_t b_y,
    input  wire data_t b_z,
    output logic       out_valid,
    input  wire logic  out_stall,
    output data_t      res_w,
    output data_t      res_x,
    output data_t      res_y,
    output data_t      res_z
);

    logic  en;
    ctl_t  ctl0, ctl1, ctl2, ctl3, ctl4;
    op_t   lhs0 [4];
    op_t   rhs0 [4];
    op_t   lhs2 [4];
    op_t   rhs2 [4];
    prod_t prod1 [16];
    prod_t prod3 [16];
    data_t res2 [4];
    data_t res4 [4];
    data_t a1_reg [4];
    data_t a2_reg [4];

    assign en       = !(ctl4.vld && out_stall);
    assign in_stall = !en;

    assign ctl0.vld = in_valid;
    assign ctl0.rot = req_type;

    assign lhs0[0] = OP_W'(a_w);
    assign lhs0[1] = OP_W'(a_x);
    assign lhs0[2] = OP_W'(a_y);
    assign lhs0[3] = OP_W'(a_z);
    assign rhs0[0] = (req_type == REQ_ROTATE) ? '0 : OP_W'(b_w);
    assign rhs0[1] = OP_W'(b_x);
    assign rhs0[2] = OP_W'(b_y);
    assign rhs0[3] = OP_W'(b_z);

    // carry a alongside the first product and its sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg[0] <= a_w;
            a1_reg[1] <= a_x;
            a1_reg[2] <= a_y;
            a1_reg[3] <= a_z;
            a2_reg    <= a1_reg;
        end
    end

    qmr_mult_stage u_mult1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl0),
        .lhs     (lhs0),
        .rhs     (rhs0),
        .ctl_out (ctl1),
        .prod    (prod1)
    );

    qmr_sum_stage u_sum1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl1),
        .prod    (prod1),
        .ctl_out (ctl2),
        .res     (res2)
    );

    // rotate: multiply by conj(a); product: multiply by one
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            lhs2[k] = OP_W'(res2[k]);
        end
        if (ctl2.rot == REQ_ROTATE)
        begin
            rhs2[0] = OP_W'(a2_reg[0]);
            rhs2[1] = -OP_W'(a2_reg[1]);
            rhs2[2] = -OP_W'(a2_reg[2]);
            rhs2[3] = -OP_W'(a2_reg[3]);
        end
        else
        begin
            rhs2[0] = ONE_Q;
            rhs2[1] = '0;
            rhs2[2] = '0;
            rhs2[3] = '0;
        end
    end

    qmr_mult_stage u_mult2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl2),
        .lhs     (lhs2),
        .rhs     (rhs2),
        .ctl_out (ctl3),
        .prod    (prod3)
    );

    qmr_sum_stage u_sum2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl3),
        .prod    (prod3),
        .ctl_out (ctl4),
        .res     (res4)
    );

    assign out_valid = ctl4.vld;
    assign res_w     = (ctl4.rot == REQ_ROTATE) ? '0 : res4[0];
    assign res_x     = res4[1];
    assign res_y     = res4[2];
    assign res_z     = res4[3];

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without an output stall");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> ctl1.vld)
        else $error("accepted transaction missing from first stage");

    a_rot_zero_w: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ctl4.rot == REQ_ROTATE) |-> (res_w == '0))
        else $error("rotation result with nonzero scalar");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl3.vld && !in_stall) |=> out_valid)
        else $error("transaction lost in last stage");

endmodule

`default_nettype wire

>>> tb/quaternion_multiply_rotate_test.sv
`timescale 1ns / 100ps

module quaternion_multiply_rotate_test;

    import qmr_pkg::*;

    localparam int   RANDOM_ITEMS = 900;
    localparam int   QUIET_FROM   = 780;
    localparam int   CYCLE_LIMIT  = 200000;
    localparam int   NUM_ROWS     = 18;

    localparam data_t Q_ZERO    = 32'sh0000_0000;
    localparam data_t Q_ONE     = 32'sh0001_0000;
    localparam data_t Q_MAX     = 32'sh7FFF_FFFF;
    localparam data_t Q_MIN     = 32'sh8000_0000;
    localparam data_t Q_LSB     = 32'sh0000_0001;
    localparam data_t Q_NEG_LSB = 32'shFFFF_FFFF;
    localparam data_t Q_COS45   = 32'sh0000_B505;
    localparam data_t Q_ALT_A   = 32'shAAAA_AAAA;
    localparam data_t Q_ALT_5   = 32'sh5555_5555;
    localparam data_t Q_SAMPLE  = 32'sh1234_5678;

    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    typedef logic signed [79:0] acc_t;

    typedef struct packed {
        data_t w;
        data_t x;
        data_t y;
        data_t z;
    } quat_t;

    typedef struct packed {
        acc_t w;
        acc_t x;
        acc_t y;
        acc_t z;
    } wide_quat_t;

    typedef struct packed {
        logic  req;
        quat_t a;
        quat_t b;
    } quat_op_t;

    typedef struct packed {
        quat_op_t op;
        logic     typed;
        quat_t    want;
    } directed_row_t;

    localparam quat_t NO_RESULT = '0;
    localparam acc_t  POS_LIMIT = acc_t'(64'sh7FFF_FFFF);
    localparam acc_t  NEG_LIMIT = -POS_LIMIT - acc_t'(1);

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    logic  req_type;
    data_t a_w, a_x, a_y, a_z;
    data_t b_w, b_x, b_y, b_z;
    logic  out_valid;
    logic  out_stall = 1'b0;
    data_t res_w, res_x, res_y, res_z;

    quat_t         pending_results[$];
    quat_t         head_result;
    directed_row_t directed_rows[NUM_ROWS];
    logic          idle_enable;
    int            stall_left  = 0;
    int            cycle_count = 0;
    int            errors      = 0;

    quaternion_multiply_rotate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .a_w       (a_w),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .b_w       (b_w),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_w     (res_w),
        .res_x     (res_x),
        .res_y     (res_y),
        .res_z     (res_z)
    );

    function automatic acc_t frac_product(input acc_t x, input acc_t y);
        acc_t p;
        p = x * y;
        return p >>> FRAC_BITS;
    endfunction

    function automatic data_t clamp_q(input acc_t s);
        if (s > POS_LIMIT)
        begin
            return Q_MAX;
        end
        if (s < NEG_LIMIT)
        begin
            return Q_MIN;
        end
        return s[DATA_WIDTH-1:0];
    endfunction

    function automatic wide_quat_t widen(input quat_t q);
        wide_quat_t r;
        r.w = acc_t'(q.w);
        r.x = acc_t'(q.x);
        r.y = acc_t'(q.y);
        r.z = acc_t'(q.z);
        return r;
    endfunction

    function automatic quat_t hamilton(input wide_quat_t l, input wide_quat_t r);
        quat_t q;
        q.w = clamp_q(frac_product(l.w, r.w) - frac_product(l.x, r.x)
                    - frac_product(l.y, r.y) - frac_product(l.z, r.z));
        q.x = clamp_q(frac_product(l.w, r.x) + frac_product(l.x, r.w)
                    + frac_product(l.y, r.z) - frac_product(l.z, r.y));
        q.y = clamp_q(frac_product(l.w, r.y) - frac_product(l.x, r.z)
                    + frac_product(l.y, r.w) + frac_product(l.z, r.x));
        q.z = clamp_q(frac_product(l.w, r.z) + frac_product(l.x, r.y)
                    - frac_product(l.y, r.x) + frac_product(l.z, r.w));
        return q;
    endfunction

    function automatic quat_t predict_result(input quat_op_t op);
        wide_quat_t wa;
        wide_quat_t wb;
        wide_quat_t conj_a;
        quat_t      q;
        wa = widen(op.a);
        wb = widen(op.b);
        if (op.req == REQ_ROTATE)
        begin
            wb.w = '0;
            q = hamilton(wa, wb);
            conj_a.w = wa.w;
            conj_a.x = -wa.x;
            conj_a.y = -wa.y;
            conj_a.z = -wa.z;
            q = hamilton(widen(q), conj_a);
            q.w = Q_ZERO;
        end
        else
        begin
            q = hamilton(wa, wb);
        end
        return q;
    endfunction

    function automatic data_t pick_component();
        case ($urandom_range(0, 9))
            0: return Q_MIN;
            1: return Q_MAX;
            2, 3, 4: return data_t'($urandom);
            default: return data_t'($urandom_range(0, 262143)) - data_t'(131072);
        endcase
    endfunction

    function automatic quat_op_t random_op();
        quat_op_t op;
        op.req = $urandom_range(0, 1) ? REQ_ROTATE : REQ_PRODUCT;
        op.a.w = pick_component();
        op.a.x = pick_component();
        op.a.y = pick_component();
        op.a.z = pick_component();
        op.b.w = pick_component();
        op.b.x = pick_component();
        op.b.y = pick_component();
        op.b.z = pick_component();
        return op;
    endfunction

    task automatic offer(input quat_op_t op, input logic typed, input quat_t want,
                         input bit idle_ok);
        int gap;
        if (idle_ok && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= op.req;
        a_w <= op.a.w;
        a_x <= op.a.x;
        a_y <= op.a.y;
        a_z <= op.a.z;
        b_w <= op.b.w;
        b_x <= op.b.x;
        b_y <= op.b.y;
        b_z <= op.b.z;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        pending_results.push_back(typed ? want : predict_result(op));
    endtask

    task automatic check_field(input string field, input data_t want, input data_t got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            errors++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // stall the result side in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idle_enable && $urandom_range(0, 7) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 14);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h %h %h %h",
                         $time, res_w, res_x, res_y, res_z);
                errors++;
            end
            else
            begin
                head_result = pending_results.pop_front();
                check_field("res_w", head_result.w, res_w);
                check_field("res_x", head_result.x, res_x);
                check_field("res_y", head_result.y, res_y);
                check_field("res_z", head_result.z, res_z);
            end
        end
    end

    initial
    begin
        bit idle_now;
        in_valid    = 1'b0;
        req_type    = REQ_PRODUCT;
        {a_w, a_x, a_y, a_z} = '0;
        {b_w, b_x, b_y, b_z} = '0;
        idle_enable = 1'b0;

        directed_rows[0]  = {REQ_PRODUCT, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO,
                             Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO,
                             TYPED, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO};
        directed_rows[1]  = {REQ_PRODUCT, {4{Q_ZERO}}, {4{Q_ZERO}},
                             TYPED, {4{Q_ZERO}}};
        directed_rows[2]  = {REQ_PRODUCT, {4{Q_MAX}}, {4{Q_MAX}},
                             TYPED, Q_MIN, Q_MAX, Q_MAX, Q_MAX};
        directed_rows[3]  = {REQ_PRODUCT, {4{Q_MIN}}, {4{Q_MIN}},
                             TYPED, Q_MIN, Q_MAX, Q_MAX, Q_MAX};
        directed_rows[4]  = {REQ_PRODUCT, {4{Q_MAX}}, {4{Q_MIN}},
                             PREDICTED, NO_RESULT};
        directed_rows[5]  = {REQ_PRODUCT, Q_NEG_LSB, Q_ZERO, Q_ZERO, Q_ZERO,
                             Q_LSB, Q_ZERO, Q_ZERO, Q_ZERO,
                             TYPED, Q_NEG_LSB, Q_ZERO, Q_ZERO, Q_ZERO};
        directed_rows[6]  = {REQ_PRODUCT, {4{Q_ALT_A}}, {4{Q_ALT_5}},
                             PREDICTED, NO_RESULT};
        directed_rows[7]  = {REQ_PRODUCT, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO,
                             Q_MIN, Q_MAX, Q_MIN, Q_MAX,
                             TYPED, Q_MIN, Q_MAX, Q_MIN, Q_MAX};
        directed_rows[8]  = {REQ_ROTATE, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO,
                             Q_MAX, Q_MAX, Q_MIN, Q_SAMPLE,
                             TYPED, Q_ZERO, Q_MAX, Q_MIN, Q_SAMPLE};
        directed_rows[9]  = {REQ_ROTATE, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO,
                             Q_MIN, Q_MAX, Q_MIN, Q_SAMPLE,
                             TYPED, Q_ZERO, Q_MAX, Q_MIN, Q_SAMPLE};
        directed_rows[10] = {REQ_ROTATE, Q_ZERO, Q_MIN, Q_ZERO, Q_ZERO,
                             Q_ZERO, Q_ONE, Q_ONE, Q_ONE,
                             PREDICTED, NO_RESULT};
        directed_rows[11] = {REQ_ROTATE, {4{Q_MIN}}, {4{Q_MIN}},
                             PREDICTED, NO_RESULT};
        directed_rows[12] = {REQ_ROTATE, {4{Q_MAX}}, {4{Q_MAX}},
                             PREDICTED, NO_RESULT};
        directed_rows[13] = {REQ_ROTATE, Q_COS45, Q_ZERO, Q_ZERO, Q_COS45,
                             Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO,
                             PREDICTED, NO_RESULT};
        directed_rows[14] = {REQ_ROTATE, {4{Q_ALT_5}}, {4{Q_ALT_A}},
                             PREDICTED, NO_RESULT};
        directed_rows[15] = {REQ_ROTATE, {4{Q_ZERO}}, {4{Q_ZERO}},
                             TYPED, {4{Q_ZERO}}};
        directed_rows[16] = {REQ_ROTATE, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO,
                             Q_SAMPLE, Q_NEG_LSB, Q_LSB, Q_ZERO,
                             TYPED, Q_ZERO, Q_NEG_LSB, Q_LSB, Q_ZERO};
        directed_rows[17] = {REQ_ROTATE, Q_ZERO, Q_ZERO, Q_ZERO, Q_NEG_LSB,
                             Q_ZERO, Q_MAX, Q_MAX, Q_MAX,
                             PREDICTED, NO_RESULT};

        @(posedge rst_n);
        @(posedge clk);
        idle_enable <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            offer(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].want, 1'b1);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // hold off idling for one stretch in three and for the tail
            idle_now = (n < QUIET_FROM) && ((n / 150) % 3 != 2);
            idle_enable <= idle_now;
            offer(random_op(), PREDICTED, NO_RESULT, idle_now);
        end

        in_valid    <= 1'b0;
        idle_enable <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        if (errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
